// File: hw/rtl/ectl_pkg.sv
// ----------------------------------------------------------------------------
// ectl_pkg
// Shared constants, types and tables for the epoch to local calendar block.
// ----------------------------------------------------------------------------
package ectl_pkg;

  // Pipeline depth: input register, four work stages, output register
  localparam int NUM_STAGES = 6;
  typedef logic [NUM_STAGES-1:0] stage_en_t;

  // Field widths
  localparam int EPOCH_W  = 32;
  localparam int TOTAL_W  = 33;
  localparam int TOD_W    = 17;
  localparam int DAY_W    = 16;
  localparam int YEAR_W   = 7;
  localparam int MONTH_W  = 4;
  localparam int DOM_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int SEC_W    = 6;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  // Time constants
  localparam int SEC_PER_MIN    = 60;
  localparam int SEC_PER_HOUR   = 3600;
  localparam int LOCAL_OFFSET_H = 8;
  localparam logic [TOTAL_W-1:0] LOCAL_OFFSET_SEC = TOTAL_W'(LOCAL_OFFSET_H * SEC_PER_HOUR);

  // Seconds per day is 128 * 675: shift by 7, then divide by 675
  localparam int DAY_SHIFT    = 7;
  localparam int DAY_ODD_DIV  = 675;
  localparam int DIV675_SHIFT = 36;
  localparam logic [27:0] DIV675_MUL =
    28'(((64'd1 << DIV675_SHIFT) + 64'd674) / 64'd675);

  // Four-year cycles counted from 1968-03-01
  localparam int CYCLE_DAYS = 1461;
  localparam int YEAR_DAYS  = 365;
  localparam logic [DAY_W-1:0] CYCLE_OFFSET_DAYS = 16'd671;   // 1968-03-01 .. 1970-01-01
  localparam logic [DAY_W-1:0] NO_LEAP_2100_DAY  = 16'd48212; // 2100-03-01
  localparam int DIV1461_SHIFT = 27;
  localparam logic [17:0] DIV1461_MUL =
    18'(((64'd1 << DIV1461_SHIFT) + 64'd1460) / 64'd1461);

  // Time of day splits
  localparam int DIV3600_SHIFT = 29;
  localparam logic [17:0] DIV3600_MUL =
    18'(((64'd1 << DIV3600_SHIFT) + 64'd3599) / 64'd3600);
  localparam int DIV60_SHIFT = 23;
  localparam logic [17:0] DIV60_MUL =
    18'(((64'd1 << DIV60_SHIFT) + 64'd59) / 64'd60);

  // Year of century bias: cycle base year 1968
  localparam int CYCLE_BASE_YEAR = 1968;
  localparam logic [7:0] YEAR_BIAS = 8'(CYCLE_BASE_YEAR % 100);
  localparam int MARCH_MP_JAN = 10;

  // Day of a March-based year on which each month starts
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

// File: hw/rtl/ectl_day_split.sv
// ----------------------------------------------------------------------------
// ectl_day_split
// Input register, local offset and split into day count and time of day.
// ----------------------------------------------------------------------------
module ectl_day_split (
  input  logic                        clk,
  input  ectl_pkg::stage_en_t         en,
  input  logic [ectl_pkg::EPOCH_W-1:0] epoch_seconds,
  output logic [ectl_pkg::DAY_W-1:0]   day_count,
  output logic [ectl_pkg::TOD_W-1:0]   tod
);
  import ectl_pkg::*;

  logic [EPOCH_W-1:0]          epoch_reg;
  logic [TOTAL_W-1:0]          total;
  logic [TOTAL_W-DAY_SHIFT-1:0] coarse;
  logic [53:0]                 prod;
  logic [DAY_W-1:0]            days_q;
  logic [TOTAL_W-DAY_SHIFT-1:0] coarse_r;
  logic [DAY_SHIFT-1:0]        fine_r;
  logic [TOTAL_W-DAY_SHIFT-1:0] rem_full;
  logic [DAY_W-1:0]            day_shifted;
  logic [DAY_W-1:0]            day_count_next;

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (en[0]) begin
      epoch_reg <= epoch_seconds;
    end
  end

  // Apply local offset and divide by 128 * 675 via reciprocal
  assign total  = TOTAL_W'(epoch_reg) + LOCAL_OFFSET_SEC;
  assign coarse = total[TOTAL_W-1:DAY_SHIFT];
  assign prod   = 54'(coarse) * 54'(DIV675_MUL);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      days_q   <= prod[DIV675_SHIFT+DAY_W-1:DIV675_SHIFT];
      coarse_r <= coarse;
      fine_r   <= total[DAY_SHIFT-1:0];
    end
  end

  // Rebuild time of day and rebase the day count on the leap cycle
  assign rem_full    = coarse_r - (26'(days_q) * 26'(DAY_ODD_DIV));
  assign day_shifted = days_q + CYCLE_OFFSET_DAYS;
  // skip the missing leap day of 2100
  assign day_count_next = (day_shifted >= NO_LEAP_2100_DAY) ? day_shifted + 16'd1
                                                            : day_shifted;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      tod       <= {rem_full[9:0], fine_r};
      day_count <= day_count_next;
    end
  end

endmodule

// File: hw/rtl/ectl_clock.sv
// ----------------------------------------------------------------------------
// ectl_clock
// Split the time of day into hour, minute and second.
// ----------------------------------------------------------------------------
module ectl_clock (
  input  logic                         clk,
  input  ectl_pkg::stage_en_t          en,
  input  logic [ectl_pkg::TOD_W-1:0]   tod,
  output logic [ectl_pkg::HOUR_W-1:0]  hour_of_day,
  output logic [ectl_pkg::MIN_W-1:0]   minute_of_hour,
  output logic [ectl_pkg::SEC_W-1:0]   second_of_minute
);
  import ectl_pkg::*;

  logic [35:0]        prod_h;
  logic [35:0]        prod_m;
  logic [HOUR_W-1:0]  hour3;
  logic [10:0]        mins3;
  logic [TOD_W-1:0]   tod3;
  logic [TOD_W-1:0]   sec_full;
  logic [10:0]        min_full;
  logic [HOUR_W-1:0]  hour4;
  logic [MIN_W-1:0]   min4;
  logic [SEC_W-1:0]   sec4;

  // Divide by 3600 and by 60 in parallel
  assign prod_h = 36'(tod) * 36'(DIV3600_MUL);
  assign prod_m = 36'(tod) * 36'(DIV60_MUL);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      hour3 <= prod_h[DIV3600_SHIFT+HOUR_W-1:DIV3600_SHIFT];
      mins3 <= prod_m[DIV60_SHIFT+10:DIV60_SHIFT];
      tod3  <= tod;
    end
  end

  // Take remainders
  assign sec_full = tod3 - (17'(mins3) * 17'(SEC_PER_MIN));
  assign min_full = mins3 - (11'(hour3) * 11'(SEC_PER_MIN));

  always_ff @(posedge clk) begin
    if (en[4]) begin
      hour4 <= hour3;
      min4  <= min_full[MIN_W-1:0];
      sec4  <= sec_full[SEC_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en[5]) begin
      hour_of_day      <= hour4;
      minute_of_hour   <= min4;
      second_of_minute <= sec4;
    end
  end

endmodule

// File: hw/rtl/ectl_date.sv
// ----------------------------------------------------------------------------
// ectl_date
// Turn a day count from 1968-03-01 into year of century, month and day.
// ----------------------------------------------------------------------------
module ectl_date (
  input  logic                          clk,
  input  ectl_pkg::stage_en_t           en,
  input  logic [ectl_pkg::DAY_W-1:0]    day_count,
  output logic [ectl_pkg::YEAR_W-1:0]   year_of_century,
  output logic [ectl_pkg::MONTH_W-1:0]  month_number,
  output logic [ectl_pkg::DOM_W-1:0]    day_of_month
);
  import ectl_pkg::*;

  logic [33:0]       prod_c;
  logic [5:0]        cycle3;
  logic [DAY_W-1:0]  day3;
  logic [DAY_W-1:0]  rem_full;
  logic [10:0]       rem;
  logic [1:0]        yoe;
  logic [8:0]        doy;
  logic [7:0]        ybase;
  logic [8:0]        doy4;
  logic [7:0]        ybase4;
  logic [3:0]        mp;
  logic [8:0]        dom_full;
  logic [7:0]        yoff;
  logic [7:0]        ybiased;
  logic [7:0]        ymod;

  // Count whole four-year cycles
  assign prod_c = 34'(day_count) * 34'(DIV1461_MUL);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      cycle3 <= prod_c[DIV1461_SHIFT+5:DIV1461_SHIFT];
      day3   <= day_count;
    end
  end

  // Year within the cycle and day within that year
  assign rem_full = day3 - (16'(cycle3) * 16'(CYCLE_DAYS));
  assign rem      = rem_full[10:0];
  assign yoe      = 2'(rem >= 11'(YEAR_DAYS)) + 2'(rem >= 11'(2 * YEAR_DAYS))
                  + 2'(rem >= 11'(3 * YEAR_DAYS));

  always_comb begin
    case (yoe)
      2'd0:    doy = rem[8:0];
      2'd1:    doy = 9'(rem - 11'(YEAR_DAYS));
      2'd2:    doy = 9'(rem - 11'(2 * YEAR_DAYS));
      default: doy = 9'(rem - 11'(3 * YEAR_DAYS));
    endcase
  end

  assign ybase = {cycle3, 2'b00} + 8'(yoe);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      doy4   <= doy;
      ybase4 <= ybase;
    end
  end

  // Month by counting month starts passed
  always_comb begin
    mp = 4'd0;
    for (int i = 1; i < 12; i++) begin
      mp = mp + 4'(doy4 >= month_start(4'(i)));
    end
  end

  assign dom_full = doy4 - month_start(mp) + 9'd1;
  assign yoff     = ybase4 + 8'(mp >= 4'(MARCH_MP_JAN));
  assign ybiased  = yoff + YEAR_BIAS;

  // Reduce modulo 100 (value stays below 300)
  always_comb begin
    if (ybiased >= 8'd200) begin
      ymod = ybiased - 8'd200;
    end else if (ybiased >= 8'd100) begin
      ymod = ybiased - 8'd100;
    end else begin
      ymod = ybiased;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en[5]) begin
      year_of_century <= ymod[YEAR_W-1:0];
      month_number    <= (mp < 4'(MARCH_MP_JAN)) ? mp + 4'd3 : mp - 4'd9;
      day_of_month    <= dom_full[DOM_W-1:0];
    end
  end

endmodule

// File: hw/rtl/epoch_to_local_calendar.sv
// Each accepted request moves through the six pipeline registers to m_tvalid,
// one request per cycle while m_tready is high; the work stages hold
// constant-reciprocal multiplies and short compare chains between them.
// Back-pressure stalls only the stages that hold data, so bubbles close up.
// Reset clears the stage valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
// epoch_to_local_calendar
// Unix seconds to local (UTC+8) Gregorian date and time of day.
// ----------------------------------------------------------------------------
module epoch_to_local_calendar (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [31:0] epoch_seconds
  input  logic [ectl_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [6:0] year_of_century, [10:7] month_number, [15:11] day_of_month,
  // [20:16] hour_of_day, [26:21] minute_of_hour, [32:27] second_of_minute,
  // [39:33] zero
  output logic [ectl_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import ectl_pkg::*;

  stage_en_t            en;
  logic [NUM_STAGES-1:0] valid;
  logic [DAY_W-1:0]     day_count;
  logic [TOD_W-1:0]     tod;
  logic [YEAR_W-1:0]    year_of_century;
  logic [MONTH_W-1:0]   month_number;
  logic [DOM_W-1:0]     day_of_month;
  logic [HOUR_W-1:0]    hour_of_day;
  logic [MIN_W-1:0]     minute_of_hour;
  logic [SEC_W-1:0]     second_of_minute;

  // Advance a stage when it is empty or the one after it advances
  always_comb begin
    en[NUM_STAGES-1] = !valid[NUM_STAGES-1] || m_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = valid[NUM_STAGES-1];

  // Track occupancy of each stage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= s_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  ectl_day_split u_split (
    .clk           (clk),
    .en            (en),
    .epoch_seconds (s_tdata[EPOCH_W-1:0]),
    .day_count     (day_count),
    .tod           (tod)
  );

  ectl_clock u_clock (
    .clk              (clk),
    .en               (en),
    .tod              (tod),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute)
  );

  ectl_date u_date (
    .clk             (clk),
    .en              (en),
    .day_count       (day_count),
    .year_of_century (year_of_century),
    .month_number    (month_number),
    .day_of_month    (day_of_month)
  );

  // Pack the result
  assign m_tdata = {7'd0, second_of_minute, minute_of_hour, hour_of_day,
                    day_of_month, month_number, year_of_century};

endmodule

// File: hw/rtl/ectl_checker.sv
// ----------------------------------------------------------------------------
// ectl_checker
// Port-level checks on the result stream of the calendar block.
// ----------------------------------------------------------------------------
module ectl_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [ectl_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import ectl_pkg::*;

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Date fields stay in calendar range
  a_date: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[6:0] <= 7'd99) && (m_tdata[10:7] >= 4'd1)
                 && (m_tdata[10:7] <= 4'd12) && (m_tdata[15:11] != 5'd0))
    else $error("date field out of range");

  // Time fields stay in range and padding is zero
  a_time: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[20:16] <= 5'd23) && (m_tdata[26:21] <= 6'd59)
                 && (m_tdata[32:27] <= 6'd59) && (m_tdata[39:33] == 7'd0))
    else $error("time field out of range");

endmodule

bind epoch_to_local_calendar ectl_checker u_ectl_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
